// File: rtl/flc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flc_pkg
// Shared types and codes of the FIFO lock coordinator.
// ----------------------------------------------------------------------------
package flc_pkg;

    localparam int NODE_COUNT_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic REQ_LOCK    = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [2:0] ST_GRANTED = 3'd0;
    localparam logic [2:0] ST_QUEUED  = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_HANDED  = 3'd3;
    localparam logic [2:0] ST_FREED   = 3'd4;
    localparam logic [2:0] ST_IGNORED = 3'd5;

    typedef struct packed {
        logic       req_type;
        logic [3:0] requester;
    } req_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic       grant_valid;
        logic [3:0] grant_node;
        logic       lock_held;
        logic [4:0] waiting_count;
    } rsp_word_t;

endpackage
`default_nettype wire

// File: rtl/fifo_lock_coordinator.sv
`default_nettype none
// Timing: a word is answered in the cycle after it is accepted; a release that hands
// the lock to a waiter answers from the S_HAND state, in which the RAM read is used.
// Throughput: one word per cycle while no response stalls and no hand-over is busy.
// Reset: rst_n clears the lock flag, holder and queue pointers; the queue RAM is
// not cleared, since an entry is only read after it has been written.
// ----------------------------------------------------------------------------
// fifo_lock_coordinator
// Grants one shared lock, queues waiting nodes in a RAM-based FIFO and hands
// the lock on in arrival order when the holder releases it.
// ----------------------------------------------------------------------------
module fifo_lock_coordinator #(
    parameter int NODE_COUNT  = flc_pkg::NODE_COUNT_DEF,
    parameter int QUEUE_DEPTH = flc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire flc_pkg::req_word_t req_word,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output flc_pkg::rsp_word_t      rsp_word
);

    import flc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = $clog2(NODE_COUNT + 1) + 4;

    typedef enum logic {S_IDLE, S_HAND} state_t;

    state_t           state_reg, state_next;
    logic             held_reg, held_next;
    logic [3:0]       holder_reg, holder_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_word_t        rsp_word_reg, rsp_word_next;

    logic             accept;
    logic             node_ok;
    logic             wr_en;
    logic [3:0]       rd_data;
    logic [CNT_W+4:0] count_wide;

    flc_ram #(
        .WIDTH (4),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (req_word.requester),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        next_pos = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign node_ok   = CMP_W'(req_word.requester) < CMP_W'(NODE_COUNT);

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        holder_next    = holder_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        wr_en          = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next  = rsp_word_reg;
        rsp_word_next.grant_valid = 1'b0;
        rsp_word_next.grant_node  = '0;
        rsp_word_next.status      = ST_IGNORED;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (node_ok && req_word.req_type == REQ_LOCK)
                    begin
                        if (!held_reg)
                        begin
                            held_next   = 1'b1;
                            holder_next = req_word.requester;
                            rsp_word_next.status      = ST_GRANTED;
                            rsp_word_next.grant_valid = 1'b1;
                            rsp_word_next.grant_node  = req_word.requester;
                        end
                        else if (count_reg < CNT_W'(QUEUE_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            tail_next  = next_pos(tail_reg);
                            count_next = count_reg + 1'b1;
                            rsp_word_next.status = ST_QUEUED;
                        end
                        else
                        begin
                            rsp_word_next.status = ST_FULL;
                        end
                    end
                    else if (node_ok && held_reg && holder_reg == req_word.requester)
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = S_HAND;
                        end
                        else
                        begin
                            held_next   = 1'b0;
                            holder_next = '0;
                            rsp_word_next.status = ST_FREED;
                        end
                    end
                    rsp_valid_next = (state_next == S_IDLE);
                end
            end
            S_HAND:
            begin
                state_next  = S_IDLE;
                holder_next = rd_data;
                head_next   = next_pos(head_reg);
                count_next  = count_reg - 1'b1;
                rsp_valid_next = 1'b1;
                rsp_word_next.status      = ST_HANDED;
                rsp_word_next.grant_valid = 1'b1;
                rsp_word_next.grant_node  = rd_data;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        count_wide = {5'b0, count_next};
        rsp_word_next.lock_held     = held_next;
        rsp_word_next.waiting_count = count_wide[4:0];
        if (!rsp_valid_next || (rsp_valid_reg && rsp_stall))
        begin
            rsp_word_next = rsp_word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= 1'b0;
            holder_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            holder_reg    <= holder_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_word_reg  <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule
`default_nettype wire

// File: rtl/flc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module flc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: rtl/flc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flc_assertions
// Port-level checks of the FIFO lock coordinator, bound to the top level.
// ----------------------------------------------------------------------------
module flc_assertions (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_stall,
    input wire flc_pkg::req_word_t req_word,
    input wire logic               rsp_valid,
    input wire logic               rsp_stall,
    input wire flc_pkg::rsp_word_t rsp_word
);

    import flc_pkg::*;

    logic req_seen;

    assign req_seen = req_valid && !req_stall;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("Stalled response word changed.");

    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_word.grant_valid ==
            (rsp_word.status == ST_GRANTED || rsp_word.status == ST_HANDED))
        else $error("Grant flag disagrees with status.");

    a_freed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status == ST_FREED |->
            !rsp_word.lock_held && rsp_word.waiting_count == '0)
        else $error("Freed lock still held or has waiters.");

    a_granted_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status == ST_GRANTED |->
            rsp_word.lock_held && rsp_word.waiting_count == '0)
        else $error("Immediate grant with waiters present.");

    a_no_rsp_without_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_seen) || $past(req_stall))
        else $error("Response without an accepted request.");

endmodule

bind fifo_lock_coordinator flc_assertions u_flc_assertions (.*);
`default_nettype wire
